[rtl/mlr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlr_pkg
// Shared types, constants and helpers for the midpoint line rasteriser.
// ----------------------------------------------------------------------------
package mlr_pkg;

  localparam int COORD_BITS = 12;
  localparam int COLOR_BITS = 24;
  // decision variable and increments: sign plus two guard bits over a coordinate
  localparam int DEC_BITS   = COORD_BITS + 3;

  // queue between classifier and stepper
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic [COLOR_BITS-1:0]      color_t;
  typedef logic signed [DEC_BITS-1:0] dec_t;

  // function codes of an input transaction
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  typedef enum logic [2:0] {
    MODE_SHALLOW_UP   = 3'd0,
    MODE_SHALLOW_DOWN = 3'd1,
    MODE_STEEP_UP     = 3'd2,
    MODE_STEEP_DOWN   = 3'd3,
    MODE_VERTICAL     = 3'd4,
    MODE_HORIZONTAL   = 3'd5
  } mode_t;

  // classified item as held in the queue
  typedef struct packed {
    logic   start;
    coord_t cur_x;
    coord_t cur_y;
    coord_t major_end;
    dec_t   decision;
    dec_t   inc_straight;
    dec_t   inc_diagonal;
    mode_t  mode;
    color_t color;
  } qentry_t;

  // queue status seen by the top level
  typedef struct packed {
    logic                  full;
    logic                  empty;
    logic [Q_CNT_BITS-1:0] count;
  } qstat_t;

  // major axis is y for steep and vertical lines
  function automatic logic is_steep(input mode_t m);
    return (m == MODE_STEEP_UP) || (m == MODE_STEEP_DOWN) || (m == MODE_VERTICAL);
  endfunction

  function automatic logic is_down(input mode_t m);
    return (m == MODE_SHALLOW_DOWN) || (m == MODE_STEEP_DOWN);
  endfunction

endpackage

[rtl/mlr_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlr_front
// Front end: classifies a start transaction into line mode and sets up the
// midpoint decision terms; step transactions pass through as a flag.
// ----------------------------------------------------------------------------
module mlr_front
  import mlr_pkg::*;
(
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    in_func,
  input  coord_t  in_x_start,
  input  coord_t  in_y_start,
  input  coord_t  in_x_end,
  input  coord_t  in_y_end,
  input  color_t  in_line_color,
  output logic    wr_valid,
  input  logic    wr_ready,
  output qentry_t wr_entry
);

  localparam int EXT_BITS = DEC_BITS - COORD_BITS;

  logic   swap;
  coord_t ax1, ay1, ax2, ay2;
  coord_t adx, ady;
  logic   down;
  dec_t   adx_e, ady_e;

  assign in_ready = wr_ready;
  assign wr_valid = in_valid;

  // order endpoints so that x ascends, then take absolute deltas
  always_comb begin
    swap  = (in_x_end < in_x_start);
    ax1   = swap ? in_x_end   : in_x_start;
    ay1   = swap ? in_y_end   : in_y_start;
    ax2   = swap ? in_x_start : in_x_end;
    ay2   = swap ? in_y_start : in_y_end;
    adx   = ax2 - ax1;
    down  = (ay2 < ay1);
    ady   = down ? (ay1 - ay2) : (ay2 - ay1);
    adx_e = dec_t'({{EXT_BITS{1'b0}}, adx});
    ady_e = dec_t'({{EXT_BITS{1'b0}}, ady});
  end

  // mode and decision set-up
  always_comb begin
    wr_entry              = '0;
    wr_entry.start        = (in_func == FUNC_START);
    wr_entry.color        = in_line_color;
    if (in_x_start == in_x_end) begin
      wr_entry.mode      = MODE_VERTICAL;
      wr_entry.cur_x     = in_x_start;
      wr_entry.cur_y     = (in_y_start < in_y_end) ? in_y_start : in_y_end;
      wr_entry.major_end = (in_y_start < in_y_end) ? in_y_end : in_y_start;
    end else if (in_y_start == in_y_end) begin
      wr_entry.mode      = MODE_HORIZONTAL;
      wr_entry.cur_y     = in_y_start;
      wr_entry.cur_x     = ax1;
      wr_entry.major_end = ax2;
    end else begin
      wr_entry.cur_x = ax1;
      wr_entry.cur_y = ay1;
      if (adx > ady) begin
        wr_entry.mode         = down ? MODE_SHALLOW_DOWN : MODE_SHALLOW_UP;
        wr_entry.decision     = (ady_e <<< 1) - adx_e;
        wr_entry.inc_straight = ady_e <<< 1;
        wr_entry.inc_diagonal = (ady_e - adx_e) <<< 1;
        wr_entry.major_end    = ax2;
      end else begin
        wr_entry.mode         = down ? MODE_STEEP_DOWN : MODE_STEEP_UP;
        wr_entry.decision     = (adx_e <<< 1) - ady_e;
        wr_entry.inc_straight = adx_e <<< 1;
        wr_entry.inc_diagonal = (adx_e - ady_e) <<< 1;
        wr_entry.major_end    = ay2;
      end
    end
  end

endmodule

[rtl/mlr_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlr_queue
// Short FIFO between classifier and stepper so each side stalls on its own.
// ----------------------------------------------------------------------------
module mlr_queue
  import mlr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_valid,
  output logic    wr_ready,
  input  qentry_t wr_entry,
  output logic    rd_valid,
  input  logic    rd_ready,
  output qentry_t rd_entry,
  output qstat_t  stat
);

  localparam logic [Q_PTR_BITS-1:0] PTR_LAST = Q_PTR_BITS'(Q_DEPTH - 1);
  localparam logic [Q_CNT_BITS-1:0] CNT_FULL = Q_CNT_BITS'(Q_DEPTH);

  qentry_t               mem_r [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_BITS-1:0] count_r, count_nxt;
  logic                  wr_en, rd_en;

  assign stat.full  = (count_r == CNT_FULL);
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;

  assign wr_ready = !stat.full;
  assign rd_valid = !stat.empty;
  assign rd_entry = mem_r[rd_ptr_r];

  assign wr_en = wr_valid && wr_ready;
  assign rd_en = rd_valid && rd_ready;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

[rtl/mlr_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlr_back
// Back end: holds the line in progress, loads it on a start transaction, takes
// one midpoint step per step transaction and registers the resulting pixel.
// ----------------------------------------------------------------------------
module mlr_back
  import mlr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    rd_valid,
  output logic    rd_ready,
  input  qentry_t rd_entry,
  output logic    out_valid,
  input  logic    out_ready,
  output coord_t  out_pixel_x,
  output coord_t  out_pixel_y,
  output color_t  out_pixel_color,
  output logic    out_pixel_valid,
  output logic    out_last_pixel
);

  // line state
  coord_t cur_x_r, cur_x_nxt;
  coord_t cur_y_r, cur_y_nxt;
  coord_t major_end_r, major_end_nxt;
  dec_t   decision_r, decision_nxt;
  dec_t   inc_straight_r, inc_straight_nxt;
  dec_t   inc_diagonal_r, inc_diagonal_nxt;
  mode_t  mode_r, mode_nxt;
  color_t held_color_r, held_color_nxt;
  logic   active_r, active_nxt;

  // output register
  logic   out_valid_r;
  coord_t pix_x_r, pix_x_nxt;
  coord_t pix_y_r, pix_y_nxt;
  color_t pix_color_r, pix_color_nxt;
  logic   pix_valid_r, pix_valid_nxt;
  logic   last_r, last_nxt;

  logic   pop;
  logic   diag;
  logic   emit;
  logic   last;
  coord_t major;

  assign rd_ready = !out_valid_r || out_ready;
  assign pop      = rd_valid && rd_ready;

  // next line state and pixel
  always_comb begin
    cur_x_nxt        = cur_x_r;
    cur_y_nxt        = cur_y_r;
    major_end_nxt    = major_end_r;
    decision_nxt     = decision_r;
    inc_straight_nxt = inc_straight_r;
    inc_diagonal_nxt = inc_diagonal_r;
    mode_nxt         = mode_r;
    held_color_nxt   = held_color_r;
    active_nxt       = active_r;
    diag             = (decision_r > 0);
    emit             = 1'b0;

    if (rd_entry.start) begin
      // new line abandons any line in progress
      cur_x_nxt        = rd_entry.cur_x;
      cur_y_nxt        = rd_entry.cur_y;
      major_end_nxt    = rd_entry.major_end;
      decision_nxt     = rd_entry.decision;
      inc_straight_nxt = rd_entry.inc_straight;
      inc_diagonal_nxt = rd_entry.inc_diagonal;
      mode_nxt         = rd_entry.mode;
      held_color_nxt   = rd_entry.color;
      emit             = 1'b1;
    end else if (active_r) begin
      decision_nxt = decision_r + (diag ? inc_diagonal_r : inc_straight_r);
      if (is_steep(mode_r)) begin
        cur_y_nxt = is_down(mode_r) ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
        if (diag) begin
          cur_x_nxt = cur_x_r + 1'b1;
        end
      end else begin
        cur_x_nxt = cur_x_r + 1'b1;
        if (diag) begin
          cur_y_nxt = is_down(mode_r) ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
        end
      end
      emit = 1'b1;
    end

    major = is_steep(mode_nxt) ? cur_y_nxt : cur_x_nxt;
    last  = (major == major_end_nxt);
    if (emit) begin
      active_nxt = !last;
    end

    // step with no line in progress gives an all-zero result
    pix_x_nxt     = emit ? cur_x_nxt      : '0;
    pix_y_nxt     = emit ? cur_y_nxt      : '0;
    pix_color_nxt = emit ? held_color_nxt : '0;
    pix_valid_nxt = emit;
    last_nxt      = emit && last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r        <= '0;
      cur_y_r        <= '0;
      major_end_r    <= '0;
      decision_r     <= '0;
      inc_straight_r <= '0;
      inc_diagonal_r <= '0;
      mode_r         <= MODE_SHALLOW_UP;
      held_color_r   <= '0;
      active_r       <= 1'b0;
    end else if (pop) begin
      cur_x_r        <= cur_x_nxt;
      cur_y_r        <= cur_y_nxt;
      major_end_r    <= major_end_nxt;
      decision_r     <= decision_nxt;
      inc_straight_r <= inc_straight_nxt;
      inc_diagonal_r <= inc_diagonal_nxt;
      mode_r         <= mode_nxt;
      held_color_r   <= held_color_nxt;
      active_r       <= active_nxt;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rd_ready) begin
      out_valid_r <= rd_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      pix_x_r     <= pix_x_nxt;
      pix_y_r     <= pix_y_nxt;
      pix_color_r <= pix_color_nxt;
      pix_valid_r <= pix_valid_nxt;
      last_r      <= last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = pix_x_r;
  assign out_pixel_y     = pix_y_r;
  assign out_pixel_color = pix_color_r;
  assign out_pixel_valid = pix_valid_r;
  assign out_last_pixel  = last_r;

endmodule

[rtl/midpoint_line_rasterizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer
// Midpoint line generator, one pixel per transaction, all octants.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid/in_ready    func, endpoints, line_color
//   out_     output     out_valid/out_ready  pixel x/y/color, pixel_valid, last
//
// One transaction per clock sustained while out_ready stays high; each step is
// one add and compare on the stepper's registered line state.
// The classifier writes into a 2-deep queue, and the stepper reads it into
// the output register.
// Reset (rst_n, synchronous) empties the queue and output and ends any line.
// Either side may stall; the queue absorbs up to two transactions.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer
  import mlr_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  logic   in_func,
  input  coord_t in_x_start,
  input  coord_t in_y_start,
  input  coord_t in_x_end,
  input  coord_t in_y_end,
  input  color_t in_line_color,
  output logic   out_valid,
  input  logic   out_ready,
  output coord_t out_pixel_x,
  output coord_t out_pixel_y,
  output color_t out_pixel_color,
  output logic   out_pixel_valid,
  output logic   out_last_pixel
);

  logic    wr_valid, wr_ready;
  qentry_t wr_entry;
  logic    rd_valid, rd_ready;
  qentry_t rd_entry;
  qstat_t  q_stat;

  mlr_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_x_start    (in_x_start),
    .in_y_start    (in_y_start),
    .in_x_end      (in_x_end),
    .in_y_end      (in_y_end),
    .in_line_color (in_line_color),
    .wr_valid      (wr_valid),
    .wr_ready      (wr_ready),
    .wr_entry      (wr_entry)
  );

  mlr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready),
    .wr_entry (wr_entry),
    .rd_valid (rd_valid),
    .rd_ready (rd_ready),
    .rd_entry (rd_entry),
    .stat     (q_stat)
  );

  mlr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .rd_valid        (rd_valid),
    .rd_ready        (rd_ready),
    .rd_entry        (rd_entry),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_pixel_valid (out_pixel_valid),
    .out_last_pixel  (out_last_pixel)
  );

  // a result without a pixel carries all-zero fields
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pixel_valid |->
      (out_pixel_x == '0) && (out_pixel_y == '0) &&
      (out_pixel_color == '0) && !out_last_pixel)
    else $error("invalid result carries non-zero fields");

  // last flag only on a real pixel
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_pixel |-> out_pixel_valid)
    else $error("last_pixel set on invalid result");

  // an accepted transaction into an empty queue leaves it non-empty
  a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && q_stat.empty |=> !q_stat.empty)
    else $error("accepted transaction lost before queue");

  // fill count stays within depth and input ready tracks it
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.count <= Q_CNT_BITS'(Q_DEPTH)) && (in_ready == !q_stat.full))
    else $error("queue fill count out of range");

endmodule
